/* sv/ils_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, widths and codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int TDATA_W  = 48;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CMP_W-1:0]         t_cmp;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_GET      = 3'd0,
        CMD_ADD_HEAD = 3'd1,
        CMD_ADD_TAIL = 3'd2,
        CMD_ADD_AT   = 3'd3,
        CMD_DEL_AT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUM
    } t_state;

    typedef struct packed {
        logic  ins;
        logic  del;
        t_cmp  pos;
        t_word value;
    } t_cell_ctl;

endpackage

/* sv/indexed_list_store.sv */
`timescale 1ns / 1ps
// Result word is registered after the execute and reduce states that follow accept.
// One command at a time (accept, shift cells, reduce read); the next is accepted
// only after the result word is loaded, later while a finished one waits on m_tready.
// All cells shift in parallel; a get is collected by a registered OR over
// cell groups, then an OR over the groups.
// Reset (synchronous, active low) empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list store of signed 32-bit entries built as a row of cells with
// get, insert at head/tail/index and delete at index.
// ----------------------------------------------------------------------------
module indexed_list_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ils_pkg::TDATA_W-1:0]   s_tdata,   // command[2:0], position[9:3], item_value[41:10]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ils_pkg::TDATA_W-1:0]   m_tdata    // read_value[31:0], status[33:32], list_length[40:34]
);

    localparam ils_pkg::t_cmp CAPC = ils_pkg::t_cmp'(ils_pkg::CAPACITY);

    ils_pkg::t_state    r_state, n_state;
    ils_pkg::t_cmd      r_cmd;
    ils_pkg::t_pos      r_pos;
    ils_pkg::t_word     r_val;
    ils_pkg::t_cnt      r_count, n_count;
    logic               r_get_ok;
    ils_pkg::t_status   r_st;
    ils_pkg::t_word     r_grp [ils_pkg::NGRP];
    ils_pkg::t_word     n_grp [ils_pkg::NGRP];
    logic               r_out_valid;
    ils_pkg::t_word     r_out_rd;
    ils_pkg::t_status   r_out_st;
    ils_pkg::t_len      r_out_len;

    ils_pkg::t_cell_ctl w_ctl;
    ils_pkg::t_status   w_st;
    logic               w_get_ok;
    logic               w_accept;
    logic               w_load_out;
    ils_pkg::t_word     w_rd_or;
    ils_pkg::t_word     w_val [ils_pkg::CAPACITY];
    ils_pkg::t_word     w_hit [ils_pkg::CAPACITY];

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < ils_pkg::CAPACITY; i++) begin : g_cell
        ils_pkg::t_word w_left;
        ils_pkg::t_word w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end
        if (i == ils_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end
        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_index (ils_pkg::t_idx'(i)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[i]),
            .o_hit   (w_hit[i])
        );
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb begin
        ils_pkg::t_cmp posc;
        ils_pkg::t_cmp cntc;
        ils_pkg::t_cmp ins_pos;
        logic          is_ins;
        logic          do_ins;
        logic          do_del;
        posc     = ils_pkg::t_cmp'(r_pos);
        cntc     = ils_pkg::t_cmp'(r_count);
        ins_pos  = posc;
        is_ins   = 1'b0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        w_st     = ils_pkg::ST_OK;
        w_get_ok = 1'b0;
        unique case (r_cmd)
            ils_pkg::CMD_GET: begin
                if (posc < cntc) begin
                    w_get_ok = 1'b1;
                end else begin
                    w_st = ils_pkg::ST_BAD_POS;
                end
            end
            ils_pkg::CMD_ADD_HEAD: begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            ils_pkg::CMD_ADD_TAIL: begin
                is_ins  = 1'b1;
                ins_pos = cntc;
            end
            ils_pkg::CMD_ADD_AT: begin
                is_ins  = 1'b1;
            end
            ils_pkg::CMD_DEL_AT: begin
                if (posc < cntc) begin
                    do_del = 1'b1;
                end else begin
                    w_st = ils_pkg::ST_BAD_POS;
                end
            end
            default: begin
                w_st = ils_pkg::ST_BAD_POS;
            end
        endcase
        if (is_ins) begin
            if (ins_pos > cntc) begin
                w_st = ils_pkg::ST_BAD_POS;
            end else if (cntc >= CAPC) begin
                w_st = ils_pkg::ST_FULL;
            end else begin
                do_ins = 1'b1;
            end
        end

        w_ctl.ins   = do_ins && (r_state == ils_pkg::S_EXEC);
        w_ctl.del   = do_del && (r_state == ils_pkg::S_EXEC);
        w_ctl.pos   = ins_pos;
        w_ctl.value = r_val;

        w_accept   = 1'b0;
        w_load_out = 1'b0;
        n_count    = r_count;
        n_state    = r_state;
        unique case (r_state)
            ils_pkg::S_IDLE: begin
                w_accept = s_tvalid;
                if (s_tvalid) begin
                    n_state = ils_pkg::S_EXEC;
                end
            end
            ils_pkg::S_EXEC: begin
                if (w_ctl.ins) begin
                    n_count = r_count + 1'b1;
                end else if (w_ctl.del) begin
                    n_count = r_count - 1'b1;
                end
                n_state = ils_pkg::S_SUM;
            end
            ils_pkg::S_SUM: begin
                if (!r_out_valid || m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ils_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ils_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready = (r_state == ils_pkg::S_IDLE);

    // ------------------------------------------------------------------
    // Read tree: groups of cells, then groups
    // ------------------------------------------------------------------
    always_comb begin
        for (int g = 0; g < ils_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < ils_pkg::GRP; j++) begin
                if (g * ils_pkg::GRP + j < ils_pkg::CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_hit[g * ils_pkg::GRP + j];
                end
            end
        end
    end

    always_comb begin
        w_rd_or = '0;
        for (int g = 0; g < ils_pkg::NGRP; g++) begin
            w_rd_or = w_rd_or | r_grp[g];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ils_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= ils_pkg::t_cmd'(s_tdata[2:0]);
            r_pos <= s_tdata[9:3];
            r_val <= ils_pkg::t_word'(s_tdata[41:10]);
        end
        if (r_state == ils_pkg::S_EXEC) begin
            r_st     <= w_st;
            r_get_ok <= w_get_ok;
            r_grp    <= n_grp;
        end
        if (w_load_out) begin
            r_out_rd  <= r_get_ok ? w_rd_or : '0;
            r_out_st  <= r_st;
            r_out_len <= ils_pkg::t_len'(r_count);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'b0, r_out_len, r_out_st, r_out_rd};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ils_pkg::t_cmp'(r_count) <= CAPC)
        else $error("list length above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ils_pkg::S_EXEC |=>
            (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
            (r_count == $past(r_count) - 1'b1))
        else $error("length moved by more than one");

    a_count_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ils_pkg::S_EXEC |=> r_count == $past(r_count))
        else $error("length changed outside execute");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_st == ils_pkg::ST_FULL |->
            r_out_len == ils_pkg::t_len'(ils_pkg::CAPACITY))
        else $error("full status with list not full");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_rd != '0 |-> r_out_st == ils_pkg::ST_OK)
        else $error("read data on failed command");

endmodule

/* sv/ils_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an entry, takes its left neighbor on insert and its
// right neighbor on delete, and offers its entry when addressed.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic              i_clk,
    input  ils_pkg::t_idx     i_index,
    input  ils_pkg::t_cell_ctl i_ctl,
    input  ils_pkg::t_word    i_left,
    input  ils_pkg::t_word    i_right,
    output ils_pkg::t_word    o_value,
    output ils_pkg::t_word    o_hit
);

    ils_pkg::t_word r_val;
    ils_pkg::t_word n_val;
    ils_pkg::t_cmp  w_idx;

    assign w_idx = ils_pkg::t_cmp'(i_index);

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (w_idx > i_ctl.pos) begin
                n_val = i_left;
            end else if (w_idx == i_ctl.pos) begin
                n_val = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (w_idx >= i_ctl.pos) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_hit   = (w_idx == i_ctl.pos) ? r_val : '0;

endmodule

/* bench/tb_indexed_list_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking bench for the indexed list store. A short table of commands
// covers empty-list errors, extreme values, append by index and the spare
// command codes. Random segments then push the list toward full, toward
// empty and around the middle. Every result word is checked field by field
// against the table or a behavioral list model, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;

    localparam int           STALL_LIMIT  = 2000;
    localparam int           SEG_ITEMS    = 100;
    localparam int           NUM_SEGS     = 13;
    localparam int           DRAIN_CYCLES = 12;
    localparam logic [2:0]   CMD_SPARE_A  = 3'd5;
    localparam logic [2:0]   CMD_SPARE_B  = 3'd6;
    localparam logic [2:0]   CMD_SPARE_C  = 3'd7;
    localparam bit           TYPED        = 1'b1;
    localparam bit           MODELED      = 1'b0;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    typedef struct packed {
        ils_pkg::t_word rd;
        logic [1:0]     st;
        ils_pkg::t_len  len;
    } t_list_result;

    typedef struct packed {
        logic [2:0]     cmd;
        ils_pkg::t_pos  pos;
        ils_pkg::t_word val;
        bit             typed;
        t_list_result   res;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [ils_pkg::TDATA_W-1:0] s_tdata;   // command[2:0], position[9:3], item_value[41:10]
    logic                        m_tvalid;
    logic                        m_tready;
    logic [ils_pkg::TDATA_W-1:0] m_tdata;   // read_value[31:0], status[33:32], list_length[40:34]

    ils_pkg::t_word list_entries [ils_pkg::CAPACITY];
    int             list_count;
    t_list_result   pending_results [$];
    bit             row_typed;
    t_list_result   row_expect;
    bit             quiet;
    int             error_count;
    int             stall_cycles;

    t_dir_row directed_rows [24] = '{
        '{ils_pkg::CMD_GET, 7'd0, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd0}},
        '{ils_pkg::CMD_DEL_AT, 7'd0, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd0}},
        '{ils_pkg::CMD_ADD_AT, 7'd1, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd0}},
        '{ils_pkg::CMD_ADD_AT, 7'd127, 32'h1234_5678, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd0}},
        '{ils_pkg::CMD_ADD_AT, 7'd0, 32'h7FFF_FFFF, TYPED, '{32'h0, ils_pkg::ST_OK, 7'd1}},
        '{ils_pkg::CMD_ADD_HEAD, 7'd0, 32'h8000_0000, TYPED, '{32'h0, ils_pkg::ST_OK, 7'd2}},
        '{ils_pkg::CMD_ADD_TAIL, 7'd99, 32'hFFFF_FFFF, TYPED, '{32'h0, ils_pkg::ST_OK, 7'd3}},
        '{ils_pkg::CMD_GET, 7'd0, 32'h0000_0000, TYPED, '{32'h8000_0000, ils_pkg::ST_OK, 7'd3}},
        '{ils_pkg::CMD_GET, 7'd1, 32'hFFFF_FFFF, TYPED, '{32'h7FFF_FFFF, ils_pkg::ST_OK, 7'd3}},
        '{ils_pkg::CMD_GET, 7'd2, 32'h0000_0000, TYPED, '{32'hFFFF_FFFF, ils_pkg::ST_OK, 7'd3}},
        '{ils_pkg::CMD_GET, 7'd3, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd3}},
        '{ils_pkg::CMD_GET, 7'd127, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd3}},
        '{CMD_SPARE_A, 7'd0, 32'h0000_0055, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd3}},
        '{CMD_SPARE_B, 7'd1, 32'h0000_0000, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd3}},
        '{CMD_SPARE_C, 7'd127, 32'hFFFF_FFFF, TYPED, '{32'h0, ils_pkg::ST_BAD_POS, 7'd3}},
        '{ils_pkg::CMD_ADD_AT, 7'd3, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_ADD_AT, 7'd1, 32'h5555_5555, MODELED, '0},
        '{ils_pkg::CMD_ADD_AT, 7'd6, 32'hAAAA_AAAA, MODELED, '0},
        '{ils_pkg::CMD_GET, 7'd4, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_DEL_AT, 7'd127, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_DEL_AT, 7'd0, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_DEL_AT, 7'd3, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_GET, 7'd0, 32'h0000_0000, MODELED, '0},
        '{ils_pkg::CMD_GET, 7'd2, 32'h0000_0000, MODELED, '0}
    };

    indexed_list_store u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] pack_cmd(logic [2:0] cmd, ils_pkg::t_pos pos,
                                             ils_pkg::t_word val);
        return {6'b0, val, pos, cmd};
    endfunction

    task automatic apply_list_cmd(input logic [47:0] w, output t_list_result r);
        logic [2:0]     cmd;
        int             pos;
        int             ins_at;
        ils_pkg::t_word val;
        cmd    = w[2:0];
        pos    = w[9:3];
        val    = w[41:10];
        r.rd   = '0;
        r.st   = ils_pkg::ST_OK;
        ins_at = -1;
        case (cmd)
            ils_pkg::CMD_GET: begin
                if (pos < list_count) r.rd = list_entries[pos];
                else r.st = ils_pkg::ST_BAD_POS;
            end
            ils_pkg::CMD_ADD_HEAD: ins_at = 0;
            ils_pkg::CMD_ADD_TAIL: ins_at = list_count;
            ils_pkg::CMD_ADD_AT:   ins_at = pos;
            ils_pkg::CMD_DEL_AT: begin
                if (pos < list_count) begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_count--;
                end else begin
                    r.st = ils_pkg::ST_BAD_POS;
                end
            end
            default: r.st = ils_pkg::ST_BAD_POS;
        endcase
        if (ins_at >= 0) begin
            if (ins_at > list_count) begin
                r.st = ils_pkg::ST_BAD_POS;
            end else if (list_count >= ils_pkg::CAPACITY) begin
                r.st = ils_pkg::ST_FULL;
            end else begin
                for (int i = list_count; i > ins_at; i--)
                    list_entries[i] = list_entries[i - 1];
                list_entries[ins_at] = val;
                list_count++;
            end
        end
        r.len = ils_pkg::t_len'(list_count);
    endtask

    function automatic logic [47:0] random_cmd_word(t_mix mix);
        int             r;
        int             add_w;
        int             del_w;
        int             sel;
        logic [2:0]     cmd;
        ils_pkg::t_pos  pos;
        ils_pkg::t_word val;
        ils_pkg::t_word corner [4];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        case (mix)
            MIX_FILL:  begin add_w = 80; del_w = 5;  end
            MIX_DRAIN: begin add_w = 10; del_w = 75; end
            default:   begin add_w = 40; del_w = 35; end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_w) begin
            sel = $urandom_range(0, 2);
            cmd = (sel == 0) ? ils_pkg::CMD_ADD_HEAD :
                  (sel == 1) ? ils_pkg::CMD_ADD_TAIL : ils_pkg::CMD_ADD_AT;
        end else if (r < add_w + del_w) begin
            cmd = ils_pkg::CMD_DEL_AT;
        end else if (r < 95) begin
            cmd = ils_pkg::CMD_GET;
        end else begin
            sel = $urandom_range(0, 2);
            cmd = (sel == 0) ? CMD_SPARE_A : (sel == 1) ? CMD_SPARE_B : CMD_SPARE_C;
        end
        sel = $urandom_range(0, 9);
        if (sel < 7)       pos = ils_pkg::t_pos'($urandom_range(0, list_count));
        else if (sel == 7) pos = ils_pkg::t_pos'((list_count < 127) ? list_count + 1 : 127);
        else               pos = ils_pkg::t_pos'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) val = corner[$urandom_range(0, 3)];
        else val = $urandom;
        return pack_cmd(cmd, pos, val);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_cmd(logic [47:0] w, bit typed, t_list_result res);
        @(negedge i_clk);
        s_tvalid   <= 1'b1;
        s_tdata    <= w;
        row_typed  <= typed;
        row_expect <= res;
        do @(posedge i_clk); while (!s_tready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_list_result pred;
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                apply_list_cmd(s_tdata, pred);
                pending_results.push_back(row_typed ? row_expect : pred);
            end
            if (m_tvalid && m_tready) begin
                got.rd  = m_tdata[31:0];
                got.st  = m_tdata[33:32];
                got.len = m_tdata[40:34];
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with none pending", got.rd, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.rd !== want.rd)   report_mismatch("read_value", got.rd, want.rd);
                    if (got.st !== want.st)   report_mismatch("status", 32'(got.st), 32'(want.st));
                    if (got.len !== want.len)
                        report_mismatch("list_length", 32'(got.len), 32'(want.len));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_mix mix;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        row_typed    = 1'b0;
        row_expect   = '0;
        quiet        = 1'b0;
        error_count  = 0;
        stall_cycles = 0;
        list_count   = 0;
        foreach (list_entries[i]) list_entries[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_cmd(pack_cmd(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val),
                     directed_rows[i].typed, directed_rows[i].res);

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            // last segment and every fourth one run without stalls
            quiet = (seg == NUM_SEGS - 1) || (seg % 4 == 3);
            mix   = (seg % 3 == 0) ? MIX_FILL : (seg % 3 == 1) ? MIX_DRAIN : MIX_BALANCED;
            repeat (SEG_ITEMS) send_cmd(random_cmd_word(mix), MODELED, '0);
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
